### design/rgbh_pkg.sv
// Shared types, sizes and request codes of the RGB histogram counter.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package rgbh_pkg;

	// Histogram geometry.
	localparam int BIN_COUNT  = 256;
	localparam int COUNT_BITS = 24;
	localparam int IDX_W      = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
	localparam int CHAN_W     = 8;
	localparam int OUT_W      = 24;
	localparam int NUM_CH     = 3;

	// Channel slots in the bank arrays.
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;
	localparam logic [OUT_W-1:0]      OUT_MAX   = '1;
	localparam logic [CHAN_W:0]       BIN_LIMIT = (CHAN_W + 1)'(BIN_COUNT);

	// Request codes.
	typedef enum logic [1:0] {
		REQ_COUNT = 2'd0,
		REQ_READ  = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic execute;
		logic wipe;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_req;
		logic wipe_last;
	} ctrl_sts_t;

	// True when a channel byte addresses an existing bin.
	function automatic logic in_bins(input logic [CHAN_W-1:0] value);
		return {1'b0, value} < BIN_LIMIT;
	endfunction

	// Clamps a stored count to the width of the result field.
	function automatic logic [OUT_W-1:0] clamp_count(input logic [COUNT_BITS-1:0] c);
		logic [32:0] ext;
		ext = 33'(c);
		if (ext > 33'(OUT_MAX)) begin
			return OUT_MAX;
		end
		return ext[OUT_W-1:0];
	endfunction

endpackage

`default_nettype wire

### design/rgbh_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the three histogram banks.
`default_nettype none

module rgbh_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                                      clk,
	input  wire logic                                      wen,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      ren,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (ren) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### design/rgbh_ctrl.sv
// Controller of the RGB histogram counter: accepts a request, sequences its
// bank access and runs the clearing pass. Depends on rgbh_pkg.
`default_nettype none

module rgbh_ctrl
	import rgbh_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire ctrl_sts_t sts,
	output logic           busy,
	output ctrl_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_WIPE   = 3'b001,
		ST_IDLE   = 3'b010,
		ST_ACCESS = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next-state logic: each request passes through the access state, with a clearing
	// pass after reset and after a clear request.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_WIPE: begin
				if (sts.wipe_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				state_d = sts.clear_req ? ST_WIPE : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WIPE;
		end else begin
			state_q <= state_d;
		end
	end

	// Commands and status.
	assign busy        = (state_q != ST_IDLE);
	assign cmd.capture = (state_q == ST_IDLE) && start;
	assign cmd.execute = (state_q == ST_ACCESS);
	assign cmd.wipe    = (state_q == ST_WIPE);

endmodule

`default_nettype wire

### design/rgbh_datapath.sv
// Datapath of the RGB histogram counter: bank RAMs, clearing address counter,
// saturating increment, saturation flag and result registers.
// Depends on rgbh_pkg and rgbh_ram.
`default_nettype none

module rgbh_datapath
	import rgbh_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctrl_cmd_t         cmd,
	output ctrl_sts_t              sts,
	input  wire logic              cfg_wen,
	input  wire logic              cfg_wdata,
	input  wire logic [1:0]        req_type,
	input  wire logic [CHAN_W-1:0] red,
	input  wire logic [CHAN_W-1:0] green,
	input  wire logic [CHAN_W-1:0] blue,
	input  wire logic [CHAN_W-1:0] bin_index,
	output logic                   done,
	output logic [OUT_W-1:0]       red_count,
	output logic [OUT_W-1:0]       green_count,
	output logic [OUT_W-1:0]       blue_count,
	output logic                   saturated
);

	logic                                gray_mode_q;
	logic                                sat_q;
	req_t                                req_q;
	logic [NUM_CH-1:0][CHAN_W-1:0]       chan_val;
	logic [NUM_CH-1:0][CHAN_W-1:0]       sel_val;
	logic [NUM_CH-1:0][IDX_W-1:0]        addr_q;
	logic [NUM_CH-1:0]                   ok_q;
	logic [NUM_CH-1:0][COUNT_BITS-1:0]   rdata;
	logic [NUM_CH-1:0][COUNT_BITS-1:0]   cur_cnt;
	logic [NUM_CH-1:0][COUNT_BITS-1:0]   new_cnt;
	logic [NUM_CH-1:0]                   bump;
	logic [NUM_CH-1:0]                   hit_max;
	logic [NUM_CH-1:0][OUT_W-1:0]        rd_cnt;
	logic [NUM_CH-1:0]                   wr_en;
	logic [NUM_CH-1:0][IDX_W-1:0]        wr_addr;
	logic [NUM_CH-1:0][COUNT_BITS-1:0]   wr_data;
	logic [IDX_W-1:0]                    wipe_cnt_q;
	logic                                wipe_last;
	logic [NUM_CH-1:0][OUT_W-1:0]        count_q;
	logic                                sat_next;
	logic                                is_read;
	logic                                is_count;
	logic                                is_clear;
	logic                                done_q;
	logic                                saturated_q;

	assign chan_val[CH_RED]   = red;
	assign chan_val[CH_GREEN] = green;
	assign chan_val[CH_BLUE]  = blue;
	assign is_read  = (req_type == REQ_READ);
	assign is_count = cmd.execute && (req_q == REQ_COUNT);
	assign is_clear = (req_q == REQ_CLEAR);

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gray_mode_q <= 1'b0;
		end else if (cfg_wen) begin
			gray_mode_q <= cfg_wdata;
		end
	end

	// Request capture at the accepting beat.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_t'(req_type);
		end
	end

	// Clearing pass address: walks every bin once and wraps back to zero.
	assign wipe_last = (wipe_cnt_q == IDX_W'(BIN_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_cnt_q <= '0;
		end else if (cmd.wipe) begin
			wipe_cnt_q <= wipe_last ? '0 : wipe_cnt_q + IDX_W'(1);
		end
	end

	assign sts.clear_req = is_clear;
	assign sts.wipe_last = wipe_last;

	for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_chan
		// A read looks up bin_index in every bank; a count uses the channel byte.
		assign sel_val[ch] = is_read ? bin_index : chan_val[ch];

		always_ff @(posedge clk) begin
			if (cmd.capture) begin
				addr_q[ch] <= sel_val[ch][IDX_W-1:0];
				ok_q[ch]   <= in_bins(sel_val[ch]);
			end
		end

		// The clearing pass writes zero; otherwise a count writes the new value.
		assign wr_en[ch]   = cmd.wipe || bump[ch];
		assign wr_addr[ch] = cmd.wipe ? wipe_cnt_q : addr_q[ch];
		assign wr_data[ch] = cmd.wipe ? '0 : new_cnt[ch];

		rgbh_ram #(
			.WIDTH(COUNT_BITS),
			.DEPTH(BIN_COUNT)
		) u_bank (
			.clk  (clk),
			.wen  (wr_en[ch]),
			.waddr(wr_addr[ch]),
			.wdata(wr_data[ch]),
			.ren  (cmd.capture),
			.raddr(sel_val[ch][IDX_W-1:0]),
			.rdata(rdata[ch])
		);

		assign cur_cnt[ch] = ok_q[ch] ? rdata[ch] : '0;
		assign new_cnt[ch] = (cur_cnt[ch] == CNT_MAX) ? cur_cnt[ch]
			: cur_cnt[ch] + COUNT_BITS'(1);
		assign hit_max[ch] = (new_cnt[ch] == CNT_MAX);
		assign rd_cnt[ch]  = ok_q[ch] ? clamp_count(cur_cnt[ch]) : '0;

		// In gray mode only the red bank counts.
		if (ch == CH_RED) begin : g_red
			assign bump[ch] = is_count && ok_q[ch];
		end else begin : g_color
			assign bump[ch] = is_count && ok_q[ch] && !gray_mode_q;
		end
	end

	// Saturation flag after the current request.
	always_comb begin
		sat_next = sat_q;
		case (req_q)
			REQ_COUNT: sat_next = sat_q | (|(bump & hit_max));
			REQ_CLEAR: sat_next = 1'b0;
			default:   sat_next = sat_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (cmd.execute) begin
			sat_q <= sat_next;
		end
	end

	// Result registers and strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.execute;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			count_q     <= (req_q == REQ_READ) ? rd_cnt : '0;
			saturated_q <= sat_next;
		end
	end

	assign done        = done_q;
	assign red_count   = count_q[CH_RED];
	assign green_count = count_q[CH_GREEN];
	assign blue_count  = count_q[CH_BLUE];
	assign saturated   = saturated_q;

endmodule

`default_nettype wire

### design/rgb_histogram_counter.sv
// RGB histogram counter: 256 bins per color bank, saturating 24-bit counts.
// An accepted request passes through the bank access state; its result beat is on the
// ports in the next cycle, marked by done for that one cycle (no receiver stall).
// A new request is taken only after the last one leaves the access state; a clear request
// adds a pass that zeroes every bin before the next accept.
// Reset starts the same pass with busy high. Depends on rgbh_pkg, rgbh_ctrl, rgbh_datapath.
`default_nettype none

module rgb_histogram_counter
	import rgbh_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              cfg_wen,
	input  wire logic              cfg_wdata,
	input  wire logic [1:0]        req_type,
	input  wire logic [CHAN_W-1:0] red,
	input  wire logic [CHAN_W-1:0] green,
	input  wire logic [CHAN_W-1:0] blue,
	input  wire logic [CHAN_W-1:0] bin_index,
	output logic                   done,
	output logic [OUT_W-1:0]       red_count,
	output logic [OUT_W-1:0]       green_count,
	output logic [OUT_W-1:0]       blue_count,
	output logic                   saturated
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	rgbh_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.busy  (busy),
		.cmd   (cmd)
	);

	rgbh_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.req_type   (req_type),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.bin_index  (bin_index),
		.done       (done),
		.red_count  (red_count),
		.green_count(green_count),
		.blue_count (blue_count),
		.saturated  (saturated)
	);

	// An accepted request occupies the access cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not enter the access cycle");

	// An accepted request gives its result beat in the cycle after the access cycle.
	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted request did not produce a result beat");

	// A result beat only follows an access cycle.
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a preceding access cycle");

	// A clear request reports the saturation flag as cleared.
	a_clear_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type == REQ_CLEAR) |=> ##1 (done && !saturated))
		else $error("clear request left the saturation flag set");

endmodule

`default_nettype wire

### dv/rgb_histogram_counter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the RGB histogram counter: directed and random
// request beats, checked against a histogram predictor kept in this file.
// Depends on rgbh_pkg and the rgb_histogram_counter top level.

module rgb_histogram_counter_tb;
	import rgbh_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_BEATS = 500;

	// Expected contents of one result beat.
	typedef struct packed {
		logic [OUT_W-1:0] red_cnt;
		logic [OUT_W-1:0] green_cnt;
		logic [OUT_W-1:0] blue_cnt;
		logic             sat;
	} hist_result_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              cfg_wen;
	logic              cfg_wdata;
	logic [1:0]        req_type;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;
	logic [CHAN_W-1:0] bin_index;
	logic              done;
	logic [OUT_W-1:0]  red_count;
	logic [OUT_W-1:0]  green_count;
	logic [OUT_W-1:0]  blue_count;
	logic              saturated;

	// Predictor state: one bank of bins per channel, the sticky flag, the mode.
	logic [COUNT_BITS-1:0] bin_counts [NUM_CH][BIN_COUNT];
	logic                  any_sat;
	logic                  gray_mode;

	hist_result_t expected_counts[$];
	hist_result_t want;
	int           err_cnt;
	int           burst_left;

	rgb_histogram_counter i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.req_type   (req_type),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.bin_index  (bin_index),
		.done       (done),
		.red_count  (red_count),
		.green_count(green_count),
		.blue_count (blue_count),
		.saturated  (saturated)
	);

	// Free-running clock, 8 ns period.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Empties every bank and drops the saturation flag.
	function automatic void clear_bins();
		for (int ch = 0; ch < NUM_CH; ch++) begin
			for (int k = 0; k < BIN_COUNT; k++) begin
				bin_counts[ch][k] = '0;
			end
		end
		any_sat = 1'b0;
	endfunction

	// Saturating increment of one bin; values past the last bin are dropped.
	function automatic void bump_bin(input int ch, input logic [CHAN_W-1:0] value);
		logic [COUNT_BITS-1:0] c;
		if (int'(value) >= BIN_COUNT) begin
			return;
		end
		c = bin_counts[ch][value];
		if (c != CNT_MAX) begin
			c = c + 1'b1;
		end
		if (c == CNT_MAX) begin
			any_sat = 1'b1;
		end
		bin_counts[ch][value] = c;
	endfunction

	// Count of one bin as it appears on the result port, clamped to its width.
	function automatic logic [OUT_W-1:0] report_bin(input int ch,
			input logic [CHAN_W-1:0] idx);
		logic [63:0] c;
		if (int'(idx) >= BIN_COUNT) begin
			return '0;
		end
		c = 64'(bin_counts[ch][idx]);
		if (c > 64'(OUT_MAX)) begin
			return OUT_MAX;
		end
		return OUT_W'(c);
	endfunction

	// Applies one request to the predicted histogram and returns its result.
	function automatic hist_result_t apply_request(input req_t rq,
			input logic [CHAN_W-1:0] r, g, b, idx);
		hist_result_t res;
		res = '0;
		case (rq)
			REQ_COUNT: begin
				bump_bin(CH_RED, r);
				if (!gray_mode) begin
					bump_bin(CH_GREEN, g);
					bump_bin(CH_BLUE, b);
				end
			end
			REQ_READ: begin
				res.red_cnt   = report_bin(CH_RED, idx);
				res.green_cnt = report_bin(CH_GREEN, idx);
				res.blue_cnt  = report_bin(CH_BLUE, idx);
			end
			REQ_CLEAR: begin
				clear_bins();
			end
			default: begin
			end
		endcase
		res.sat = any_sat;
		return res;
	endfunction

	// Biased bin pick: half the time a narrow range so bins repeat often.
	function automatic logic [CHAN_W-1:0] pick_bin();
		if ($urandom_range(0, 1) == 0) begin
			return CHAN_W'($urandom_range(0, 7));
		end
		return CHAN_W'($urandom_range(0, 255));
	endfunction

	// Drives one request beat, waits for it to be taken, and records its result.
	// Between bursts of random length the sender idles for a random gap.
	task automatic send_request(input req_t rq, input logic [CHAN_W-1:0] r, g, b, idx);
		int gap;
		start     <= 1'b1;
		req_type  <= rq;
		red       <= r;
		green     <= g;
		blue      <= b;
		bin_index <= idx;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		expected_counts.push_back(apply_request(rq, r, g, b, idx));
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(20, 60);
			end else begin
				burst_left = $urandom_range(1, 8);
			end
			start <= 1'b0;
			repeat (gap) begin
				@(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// Stops sending and waits until every outstanding result beat has come back.
	task automatic wait_drained();
		start <= 1'b0;
		while (expected_counts.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Writes the mode register once every outstanding result beat has come back.
	task automatic write_gray_mode(input logic mode);
		wait_drained();
		cfg_wen   <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		gray_mode = mode;
	endtask

	// Color mode: channel extremes, alternating bit patterns, back-to-back hits on
	// the same bins, reads, the unused request code and a clear.
	task automatic test_color_directed();
		write_gray_mode(1'b0);
		send_request(REQ_READ, 8'h00, 8'h00, 8'h00, 8'h00);
		send_request(REQ_COUNT, 8'h00, 8'h00, 8'h00, 8'h00);
		send_request(REQ_COUNT, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_request(REQ_COUNT, 8'h00, 8'hFF, 8'h80, 8'h00);
		send_request(REQ_COUNT, 8'h00, 8'hFF, 8'h80, 8'h00);
		send_request(REQ_COUNT, 8'hAA, 8'h55, 8'hAA, 8'h55);
		send_request(REQ_COUNT, 8'h55, 8'hAA, 8'h55, 8'hAA);
		send_request(REQ_READ, 8'h00, 8'h00, 8'h00, 8'h00);
		send_request(REQ_READ, 8'h00, 8'h00, 8'h00, 8'hFF);
		send_request(REQ_READ, 8'h00, 8'h00, 8'h00, 8'h80);
		send_request(REQ_READ, 8'h00, 8'h00, 8'h00, 8'hAA);
		send_request(REQ_READ, 8'h00, 8'h00, 8'h00, 8'h55);
		send_request(REQ_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_request(REQ_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
		send_request(REQ_READ, 8'h00, 8'h00, 8'h00, 8'h00);
		send_request(REQ_READ, 8'h00, 8'h00, 8'h00, 8'hFF);
	endtask

	// Gray mode: only the red byte counts; green and blue bins must stay put.
	task automatic test_gray_directed();
		write_gray_mode(1'b1);
		send_request(REQ_COUNT, 8'h12, 8'h34, 8'h56, 8'h00);
		send_request(REQ_COUNT, 8'h12, 8'h34, 8'h56, 8'h00);
		send_request(REQ_COUNT, 8'hFF, 8'h00, 8'h00, 8'h00);
		send_request(REQ_READ, 8'h00, 8'h00, 8'h00, 8'h12);
		send_request(REQ_READ, 8'h00, 8'h00, 8'h00, 8'h34);
		send_request(REQ_READ, 8'h00, 8'h00, 8'h00, 8'h56);
		send_request(REQ_READ, 8'h00, 8'h00, 8'h00, 8'hFF);
		send_request(REQ_NONE, 8'h00, 8'h00, 8'h00, 8'h12);
	endtask

	// Random traffic, mostly pixel counts, in phases that swap the mode.
	task automatic test_random_traffic();
		logic mode_seq [4];
		int   roll;
		req_t rq;
		mode_seq = '{1'b0, 1'b1, 1'b0, 1'b1};
		for (int ph = 0; ph < 4; ph++) begin
			write_gray_mode(mode_seq[ph]);
			for (int n = 0; n < RANDOM_BEATS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 70) begin
					rq = REQ_COUNT;
				end else if (roll < 94) begin
					rq = REQ_READ;
				end else if (roll < 96) begin
					rq = REQ_CLEAR;
				end else begin
					rq = REQ_NONE;
				end
				send_request(rq, pick_bin(), pick_bin(), pick_bin(), pick_bin());
			end
		end
	endtask

	function automatic void check_field(input string field,
			input logic [OUT_W-1:0] exp_v, input logic [OUT_W-1:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
			err_cnt++;
		end
	endfunction

	// Result checker: each done beat is matched against the oldest expectation.
	always @(posedge clk) begin
		if (done === 1'b1) begin
			if (expected_counts.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual %0h %0h %0h %0b",
					$time, red_count, green_count, blue_count, saturated);
				err_cnt++;
			end else begin
				want = expected_counts.pop_front();
				check_field("red_count", want.red_cnt, red_count);
				check_field("green_count", want.green_cnt, green_count);
				check_field("blue_count", want.blue_cnt, blue_count);
				check_field("saturated", OUT_W'(want.sat), OUT_W'(saturated));
			end
		end
	end

	// Watchdog: ends a hung run.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Test sequence.
	initial begin
		err_cnt    = 0;
		burst_left = 0;
		gray_mode  = 1'b0;
		clear_bins();
		arst_n    <= 1'b0;
		start     <= 1'b0;
		cfg_wen   <= 1'b0;
		cfg_wdata <= 1'b0;
		req_type  <= REQ_COUNT;
		red       <= '0;
		green     <= '0;
		blue      <= '0;
		bin_index <= '0;
		repeat (3) begin
			@(posedge clk);
		end
		arst_n <= 1'b1;
		@(posedge clk);

		test_color_directed();
		test_gray_directed();
		test_random_traffic();

		// Let the pipeline settle so a stray beat would still be caught.
		wait_drained();
		repeat (4) begin
			@(posedge clk);
		end
		if (expected_counts.size() != 0) begin
			$display("%0t: %0d result beats never arrived", $time, expected_counts.size());
			err_cnt++;
		end
		if (err_cnt == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
